FILE: src/mlpc_pkg.sv
// Package for the two-layer perceptron classifier: sizes, types and the
// fixed Q4.12 weight and bias tables. No dependencies.
package mlpc_pkg;

  localparam int NUM_INPUTS  = 8;
  localparam int NUM_HIDDEN  = 20;
  localparam int NUM_CLASSES = 4;
  localparam int FRAC_BITS   = 12;

  localparam int FEAT_W   = 8;
  localparam int COEF_W   = 16;
  localparam int ACC1_W   = 32;
  localparam int ACC2_W   = 48;
  localparam int HID_W    = ACC1_W - 1;
  localparam int OPND_W   = ACC1_W;
  localparam int ROW_W    = $clog2(NUM_HIDDEN);
  localparam int COL_W    = $clog2(NUM_HIDDEN);
  localparam int IN_IDX_W = $clog2(NUM_INPUTS);
  localparam int CLS_W    = $clog2(NUM_CLASSES);

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_L1,
    S_L2,
    S_FLUSH,
    S_OUT
  } state_t;

  // One MAC step issued by the controller
  typedef struct packed {
    logic             load;   // capture features
    logic             mac;    // MAC step valid
    logic             layer;  // 0: hidden layer, 1: output layer
    logic             first;  // first term of a sum: start from bias
    logic             last;   // last term: commit result
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  localparam coef_t W1 [NUM_HIDDEN][NUM_INPUTS] = '{
    '{-16'sd1678, -16'sd2911, -16'sd8542,  16'sd897,   16'sd472,   16'sd2456,
      -16'sd1332,  16'sd1239},
    '{-16'sd94,   -16'sd4036,  16'sd2122,  16'sd649,  -16'sd1468, -16'sd981,
      -16'sd605,   16'sd37},
    '{-16'sd2626, -16'sd493,  -16'sd11282, -16'sd372, -16'sd392,  -16'sd1187,
      -16'sd1109,  16'sd723},
    '{ 16'sd856,   16'sd941,   16'sd1779,  16'sd2227,  16'sd2893,  16'sd4654,
       16'sd846,  -16'sd562},
    '{ 16'sd1093,  16'sd2987,  16'sd5054,  16'sd618,   16'sd2094,  16'sd1008,
       16'sd592,   16'sd592},
    '{ 16'sd1552,  16'sd604,   16'sd714,  -16'sd1674, -16'sd4654,  16'sd2683,
       16'sd347,  -16'sd272},
    '{ 16'sd2729,  16'sd4576, -16'sd3726, -16'sd1950,  16'sd417,  -16'sd3536,
       16'sd474,  -16'sd2135},
    '{-16'sd173,  -16'sd2451,  16'sd2037,  16'sd963,  -16'sd8930,  16'sd165,
       16'sd871,  -16'sd1223},
    '{-16'sd1594, -16'sd1384, -16'sd1661,  16'sd1633,  16'sd896,   16'sd3726,
       16'sd371,  -16'sd1606},
    '{-16'sd134,   16'sd177,  -16'sd1894, -16'sd246,  -16'sd9280,  16'sd2091,
      -16'sd34,   -16'sd109},
    '{ 16'sd2523,  16'sd785,   16'sd937,  -16'sd1003,  16'sd193,  -16'sd399,
      -16'sd1055, -16'sd3673},
    '{ 16'sd250,  -16'sd545,  -16'sd15525, 16'sd227,  -16'sd1171, -16'sd68,
       16'sd295,  -16'sd753},
    '{ 16'sd2361,  16'sd3831, -16'sd680,  -16'sd1342, -16'sd983,  -16'sd2387,
       16'sd345,  -16'sd1059},
    '{-16'sd455,  -16'sd594,   16'sd1211,  16'sd1856, -16'sd1130,  16'sd921,
       16'sd514,  -16'sd145},
    '{-16'sd271,   16'sd352,   16'sd1292,  16'sd1198,  16'sd10877, 16'sd894,
       16'sd231,  -16'sd179},
    '{ 16'sd770,   16'sd2686, -16'sd2542, -16'sd1118,  16'sd2793,  16'sd4063,
       16'sd324,  -16'sd2423},
    '{ 16'sd908,   16'sd311,  -16'sd752,  -16'sd393,  -16'sd1916,  16'sd6234,
      -16'sd219,   16'sd777},
    '{-16'sd639,   16'sd3761, -16'sd1578, -16'sd3733, -16'sd1727, -16'sd1196,
       16'sd697,  -16'sd699},
    '{ 16'sd968,  -16'sd202,   16'sd131,  -16'sd976,   16'sd10006, -16'sd3808,
       16'sd46,   -16'sd366},
    '{-16'sd2443, -16'sd120,  -16'sd4712, -16'sd1557, -16'sd1119,  16'sd2201,
       16'sd707,   16'sd129}
  };

  localparam coef_t B1 [NUM_HIDDEN] = '{
     16'sd922,  -16'sd999,   16'sd708,   16'sd2324,  16'sd5460, -16'sd801,
     16'sd2714, -16'sd1486, -16'sd1781, -16'sd2085,  16'sd2555,  16'sd2685,
    -16'sd2327,  16'sd2694,  16'sd2062, -16'sd236,  -16'sd2386, -16'sd647,
    -16'sd16,    16'sd3528
  };

  localparam coef_t W2 [NUM_CLASSES][NUM_HIDDEN] = '{
    '{-16'sd433,   16'sd246,  -16'sd2077, -16'sd5010, -16'sd346,   16'sd4641,
      -16'sd3460,  16'sd415,  -16'sd3000,  16'sd5472,  16'sd1859, -16'sd6015,
      -16'sd3854,  16'sd1861,  16'sd4488,  16'sd2064, -16'sd5140,  16'sd4061,
      -16'sd1074, -16'sd3141},
    '{ 16'sd497,   16'sd591,  -16'sd7222,  16'sd5531,  16'sd4222, -16'sd3020,
       16'sd6197, -16'sd3665,  16'sd1684, -16'sd18362, 16'sd3846, -16'sd11785,
       16'sd3710,  16'sd1318, -16'sd17316, -16'sd7661, -16'sd6436, -16'sd7197,
      -16'sd21278, 16'sd4088},
    '{ 16'sd4330, -16'sd5138,  16'sd4623, -16'sd2444, -16'sd7779,  16'sd1132,
       16'sd1564, -16'sd1936, -16'sd419,   16'sd2240, -16'sd2333,  16'sd6408,
       16'sd155,  -16'sd3276,  16'sd1889,  16'sd1361,  16'sd1265, -16'sd3324,
       16'sd647,   16'sd2865},
    '{-16'sd5611,  16'sd2337, -16'sd10645, 16'sd916,  -16'sd3645, -16'sd543,
      -16'sd2330,  16'sd3803,  16'sd3230, -16'sd3860, -16'sd727,   16'sd918,
      -16'sd6512, -16'sd1578, -16'sd695,  -16'sd4465,  16'sd6440, -16'sd3956,
       16'sd2287, -16'sd3426}
  };

  localparam coef_t B2 [NUM_CLASSES] = '{
    -16'sd445, 16'sd4066, -16'sd726, -16'sd2972
  };

endpackage

FILE: src/mlpc_ctrl.sv
// Controller for the perceptron classifier: sequences the MAC steps of both
// layers and the handshakes. Depends on mlpc_pkg.
module mlpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output mlpc_pkg::cmd_t  cmd
);

  mlpc_pkg::state_t               state_r, state_nxt;
  logic [mlpc_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [mlpc_pkg::COL_W-1:0]     col_r, col_nxt;
  logic                           l1_last, l2_last;

  assign l1_last = (col_r == mlpc_pkg::COL_W'(mlpc_pkg::NUM_INPUTS - 1));
  assign l2_last = (col_r == mlpc_pkg::COL_W'(mlpc_pkg::NUM_HIDDEN - 1));

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      mlpc_pkg::S_IDLE: begin
        row_nxt = '0;
        col_nxt = '0;
        if (in_valid) state_nxt = mlpc_pkg::S_L1;
      end
      mlpc_pkg::S_L1: begin
        if (l1_last) begin
          col_nxt = '0;
          if (row_r == mlpc_pkg::ROW_W'(mlpc_pkg::NUM_HIDDEN - 1)) begin
            row_nxt   = '0;
            state_nxt = mlpc_pkg::S_L2;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      mlpc_pkg::S_L2: begin
        if (l2_last) begin
          col_nxt = '0;
          if (row_r == mlpc_pkg::ROW_W'(mlpc_pkg::NUM_CLASSES - 1)) begin
            row_nxt   = '0;
            state_nxt = mlpc_pkg::S_FLUSH;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      mlpc_pkg::S_FLUSH: state_nxt = mlpc_pkg::S_OUT;
      mlpc_pkg::S_OUT: begin
        if (!out_stall) state_nxt = mlpc_pkg::S_IDLE;
      end
      default: state_nxt = mlpc_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.row   = row_r;
    cmd.col   = col_r;
    unique case (state_r)
      mlpc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mlpc_pkg::S_L1: begin
        cmd.mac   = 1'b1;
        cmd.first = (col_r == '0);
        cmd.last  = l1_last;
      end
      mlpc_pkg::S_L2: begin
        cmd.mac   = 1'b1;
        cmd.layer = 1'b1;
        cmd.first = (col_r == '0);
        cmd.last  = l2_last;
      end
      mlpc_pkg::S_FLUSH: ;
      mlpc_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlpc_pkg::S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlpc_pkg::S_IDLE && in_valid) |=> (state_r == mlpc_pkg::S_L1))
    else $error("accepted item did not start layer 1");
  a_l1_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlpc_pkg::S_L1) |->
      (row_r < mlpc_pkg::ROW_W'(mlpc_pkg::NUM_HIDDEN) &&
       col_r < mlpc_pkg::COL_W'(mlpc_pkg::NUM_INPUTS)))
    else $error("layer 1 index out of range");
  a_l2_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlpc_pkg::S_L2) |->
      (row_r < mlpc_pkg::ROW_W'(mlpc_pkg::NUM_CLASSES) &&
       col_r < mlpc_pkg::COL_W'(mlpc_pkg::NUM_HIDDEN)))
    else $error("layer 2 index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlpc_pkg::S_OUT && out_stall) |=> (state_r == mlpc_pkg::S_OUT))
    else $error("result dropped while stalled");

endmodule

FILE: src/mlpc_dp.sv
// Datapath for the perceptron classifier: feature and hidden registers, one
// shared multiplier, accumulator, ReLU and running argmax. Depends on mlpc_pkg.
module mlpc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mlpc_pkg::cmd_t               cmd,
  input  logic [mlpc_pkg::FEAT_W-1:0]  feat [mlpc_pkg::NUM_INPUTS],
  output logic [mlpc_pkg::CLS_W-1:0]   class_index
);

  logic [mlpc_pkg::FEAT_W-1:0]       feat_r   [mlpc_pkg::NUM_INPUTS];
  logic [mlpc_pkg::HID_W-1:0]        hidden_r [mlpc_pkg::NUM_HIDDEN];
  logic signed [mlpc_pkg::OPND_W-1:0] opnd;
  mlpc_pkg::coef_t                   weight;
  logic signed [mlpc_pkg::ACC2_W-1:0] prod, prod_r;
  logic                              p_vld_r, p_layer_r, p_first_r, p_last_r;
  logic [mlpc_pkg::ROW_W-1:0]        p_row_r;
  logic signed [mlpc_pkg::ACC2_W-1:0] bias, acc_base, acc_sum, acc_r, best_r;
  logic [mlpc_pkg::CLS_W-1:0]        best_idx_r;
  logic                              better;

  // Stage 1: operand and weight select, multiply
  always_comb begin
    if (cmd.layer) begin
      opnd   = {1'b0, hidden_r[cmd.col]};
      weight = mlpc_pkg::W2[cmd.row[mlpc_pkg::CLS_W-1:0]][cmd.col];
    end else begin
      opnd   = {{(mlpc_pkg::OPND_W - mlpc_pkg::FEAT_W){1'b0}},
                feat_r[cmd.col[mlpc_pkg::IN_IDX_W-1:0]]};
      weight = mlpc_pkg::W1[cmd.row][cmd.col[mlpc_pkg::IN_IDX_W-1:0]];
    end
    prod = opnd * weight;
  end

  // Stage 2: accumulate from bias on the first term
  always_comb begin
    if (p_layer_r)
      bias = mlpc_pkg::ACC2_W'(mlpc_pkg::B2[p_row_r[mlpc_pkg::CLS_W-1:0]])
             <<< mlpc_pkg::FRAC_BITS;
    else
      bias = mlpc_pkg::ACC2_W'(mlpc_pkg::B1[p_row_r]);
    acc_base = p_first_r ? bias : acc_r;
    acc_sum  = acc_base + prod_r;
    better   = (p_row_r == '0) || (acc_sum > best_r);
  end

  // Pipeline control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.mac;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) feat_r <= feat;
    prod_r    <= prod;
    p_layer_r <= cmd.layer;
    p_first_r <= cmd.first;
    p_last_r  <= cmd.last;
    p_row_r   <= cmd.row;
    if (p_vld_r) begin
      acc_r <= acc_sum;
      if (p_last_r && !p_layer_r)
        hidden_r[p_row_r] <= acc_sum[mlpc_pkg::ACC1_W-1] ? '0 :
                             acc_sum[mlpc_pkg::HID_W-1:0];
      if (p_last_r && p_layer_r && better) begin
        best_r     <= acc_sum;
        best_idx_r <= p_row_r[mlpc_pkg::CLS_W-1:0];
      end
    end
  end

  assign class_index = best_idx_r;

  // Checks
  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mac && cmd.last) |=> (p_vld_r && p_last_r))
    else $error("last MAC term lost in pipeline");
  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !p_vld_r)
    else $error("features reloaded during a computation");
  a_first_class: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && p_layer_r && p_last_r && p_row_r == '0) |=> (best_idx_r == '0))
    else $error("argmax not seeded by class zero");

endmodule

FILE: src/mlp_classifier_8_20_4.sv
// Top level of the 8-20-4 perceptron classifier (ReLU hidden layer, argmax).
// Instantiates mlpc_ctrl and mlpc_dp; depends on mlpc_pkg.
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  input   | in_valid, in_stall, in_feature_0..7     | in
//  result  | out_valid, out_stall, out_class_index   | out
//
// One item runs from accept to result valid through 160 hidden-layer and
// 80 output-layer multiply-accumulates on the single shared MAC, then a
// flush state that drains the MAC pipeline. The next item is accepted from
// the cycle after the result is taken.
// rst_n is synchronous, active low, and idles the controller.
// out_stall holds the result; in_stall is high whenever an item is in work.
module mlp_classifier_8_20_4 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_0,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_1,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_2,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_3,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_4,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_5,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_6,
  input  logic [mlpc_pkg::FEAT_W-1:0]       in_feature_7,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlpc_pkg::CLS_W-1:0]        out_class_index
);

  mlpc_pkg::cmd_t               cmd;
  logic [mlpc_pkg::FEAT_W-1:0]  feat [mlpc_pkg::NUM_INPUTS];

  assign feat[0] = in_feature_0;
  assign feat[1] = in_feature_1;
  assign feat[2] = in_feature_2;
  assign feat[3] = in_feature_3;
  assign feat[4] = in_feature_4;
  assign feat[5] = in_feature_5;
  assign feat[6] = in_feature_6;
  assign feat[7] = in_feature_7;

  mlpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mlpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .feat        (feat),
    .class_index (out_class_index)
  );

endmodule
